>>> rtl/core/tws_pkg.sv
// Shared types, codes and constants of the timing wheel event scheduler.
// No dependencies.
package tws_pkg;

  localparam int CAPACITY_DEF  = 64;
  localparam int TIME_BITS_DEF = 32;
  localparam int HANDLE_W      = 6;
  localparam int DELAY_W       = 24;
  localparam int TAG_W         = 16;
  localparam int REM_W         = 24;
  localparam int ORDER_W       = 32;

  typedef enum logic [1:0] {
    ACT_SCHEDULE = 2'd0,
    ACT_CANCEL   = 2'd1,
    ACT_TICK     = 2'd2,
    ACT_QUERY    = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    KIND_SCHEDULE = 2'd0,
    KIND_CANCEL   = 2'd1,
    KIND_FIRED    = 2'd2,
    KIND_QUERY    = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    STAT_OK         = 2'd0,
    STAT_FULL       = 2'd1,
    STAT_NOT_QUEUED = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_QUERY,
    ST_RESP,
    ST_SCAN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [1:0]          action;
    logic [HANDLE_W-1:0] handle;
    logic [DELAY_W-1:0]  delay;
    logic [TAG_W-1:0]    payload;
  } cmd_t;

  typedef struct packed {
    logic [1:0]          kind;
    logic [1:0]          status;
    logic [HANDLE_W-1:0] out_handle;
    logic [TAG_W-1:0]    out_payload;
    logic [REM_W-1:0]    remaining;
    logic                queued;
    logic                last;
  } res_t;

  typedef struct packed {
    action_t             op;
    logic [HANDLE_W-1:0] handle;
    logic [DELAY_W-1:0]  delay;
    logic [TAG_W-1:0]    payload;
  } qitem_t;

endpackage

>>> rtl/core/tws_chan_if.sv
// Valid/ready channel carrying one payload of type T.
// No dependencies.
interface tws_chan_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/core/tws_front.sv
// Front end: accept requests, decode the action, clamp the delay, queue two deep.
// Depends on tws_pkg and tws_chan_if.
module tws_front (
  input  logic             clk,
  input  logic             rst,
  tws_chan_if.sink         cmd,
  output tws_pkg::qitem_t  qdata,
  output logic             qvalid,
  input  logic             qpop
);
  import tws_pkg::*;

  qitem_t     fifo [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  qitem_t     item;

  assign cmd.ready = (count != 2'd2);
  assign push      = cmd.valid && cmd.ready;
  assign qvalid    = (count != 2'd0);
  assign qdata     = fifo[rd_ptr];

  always_comb begin
    item.op      = action_t'(cmd.data.action);
    item.handle  = cmd.data.handle;
    item.delay   = (cmd.data.delay == '0) ? DELAY_W'(1) : cmd.data.delay;
    item.payload = cmd.data.payload;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo[wr_ptr] <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (qpop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, qpop};
    end
  end

endmodule

>>> rtl/core/tws_back.sv
// Back end: entry store, free search, due scan and result register.
// Depends on tws_pkg and tws_chan_if.
module tws_back #(
  parameter int CAPACITY  = tws_pkg::CAPACITY_DEF,
  parameter int TIME_BITS = tws_pkg::TIME_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  tws_pkg::qitem_t  qdata,
  input  logic             qvalid,
  output logic             qpop,
  tws_chan_if.source       res
);
  import tws_pkg::*;

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int RW = (TIME_BITS > REM_W) ? TIME_BITS : REM_W;

  typedef struct packed {
    logic [TIME_BITS-1:0] due;
    logic [TAG_W-1:0]     tag;
    logic [ORDER_W-1:0]   order;
  } ent_t;

  ent_t                 mem [CAPACITY];
  ent_t                 rd_data;
  ent_t                 wr_data;
  logic                 wr_en;
  logic [IW-1:0]        wr_addr;
  logic                 rd_en;
  logic [IW-1:0]        rd_addr;

  logic [CAPACITY-1:0]  valid;
  logic [TIME_BITS-1:0] now;
  logic [ORDER_W-1:0]   ic;
  state_t               state;
  state_t               state_next;
  qitem_t               cmdq;
  res_t                 resp;
  res_t                 pend;
  logic                 have_pend;
  res_t                 out_q;
  logic                 out_v;
  res_t                 idle_resp;
  res_t                 query_resp;
  res_t                 fire_resp;

  logic [CW-1:0]        scan_cnt;
  logic                 scan_issue;
  logic                 rd_vld;
  logic [IW-1:0]        rd_idx;
  logic                 found;
  logic [IW-1:0]        best;
  logic [ORDER_W-1:0]   best_age;
  logic [TAG_W-1:0]     best_tag;

  logic [IW-1:0]        free_idx;
  logic                 full;
  logic                 can_push;
  logic                 push;
  res_t                 push_data;
  logic                 in_range;
  logic [IW-1:0]        qidx;
  logic [IW-1:0]        cidx;
  logic [ORDER_W-1:0]   age;
  logic                 hit;
  logic [TIME_BITS-1:0] dt;
  logic [RW-1:0]        diff;

  always_comb begin
    free_idx = '0;
    full     = 1'b1;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (!valid[i]) begin
        free_idx = IW'(i);
        full     = 1'b0;
      end
    end
  end

  assign in_range   = ({1'b0, qdata.handle} < (HANDLE_W + 1)'(CAPACITY));
  assign qidx       = qdata.handle[IW-1:0];
  assign cidx       = cmdq.handle[IW-1:0];
  assign scan_issue = (scan_cnt < CW'(CAPACITY));
  assign age        = ic - rd_data.order;
  assign hit        = rd_vld && valid[rd_idx] && (rd_data.due == now);
  assign dt         = rd_data.due - now;
  assign diff       = RW'(dt);
  assign can_push   = !out_v || res.ready;

  always_comb begin
    idle_resp            = '0;
    idle_resp.out_handle = qdata.handle;
    if (qdata.op == ACT_SCHEDULE) begin
      idle_resp.kind       = KIND_SCHEDULE;
      idle_resp.status     = full ? STAT_FULL : STAT_OK;
      idle_resp.out_handle = full ? HANDLE_W'(0) : HANDLE_W'(free_idx);
    end else begin
      idle_resp.kind   = KIND_CANCEL;
      idle_resp.status = (in_range && valid[qidx]) ? STAT_OK : STAT_NOT_QUEUED;
    end
  end

  always_comb begin
    query_resp            = '0;
    query_resp.kind       = KIND_QUERY;
    query_resp.out_handle = cmdq.handle;
    if (({1'b0, cmdq.handle} < (HANDLE_W + 1)'(CAPACITY)) && valid[cidx]) begin
      query_resp.queued    = 1'b1;
      query_resp.remaining = (diff > RW'({REM_W{1'b1}})) ? {REM_W{1'b1}} : diff[REM_W-1:0];
    end
  end

  always_comb begin
    fire_resp             = '0;
    fire_resp.kind        = KIND_FIRED;
    fire_resp.out_handle  = HANDLE_W'(best);
    fire_resp.out_payload = best_tag;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (qvalid) begin
          unique case (qdata.op)
            ACT_SCHEDULE, ACT_CANCEL: state_next = ST_RESP;
            ACT_QUERY:                state_next = ST_QUERY;
            ACT_TICK:                 state_next = ST_SCAN;
            default:                  state_next = ST_IDLE;
          endcase
        end
      end
      ST_QUERY: state_next = ST_RESP;
      ST_RESP: begin
        if (can_push) begin
          state_next = ST_IDLE;
        end
      end
      ST_SCAN: begin
        if (!scan_issue && !rd_vld) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!have_pend || can_push) begin
          state_next = found ? ST_SCAN : ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    qpop      = 1'b0;
    push      = 1'b0;
    push_data = resp;
    rd_en     = 1'b0;
    rd_addr   = qidx;
    wr_en     = 1'b0;
    wr_addr   = free_idx;
    wr_data.due   = now + TIME_BITS'(qdata.delay);
    wr_data.tag   = qdata.payload;
    wr_data.order = ic;
    unique case (state)
      ST_IDLE: begin
        qpop  = qvalid;
        rd_en = qvalid && (qdata.op == ACT_QUERY);
        wr_en = qvalid && (qdata.op == ACT_SCHEDULE) && !full;
      end
      ST_RESP: begin
        push = can_push;
      end
      ST_SCAN: begin
        rd_en   = scan_issue;
        rd_addr = scan_cnt[IW-1:0];
      end
      ST_DONE: begin
        push           = have_pend && can_push;
        push_data      = pend;
        push_data.last = !found;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      valid     <= '0;
      now       <= '0;
      ic        <= '0;
      out_v     <= 1'b0;
      have_pend <= 1'b0;
      found     <= 1'b0;
      rd_vld    <= 1'b0;
      scan_cnt  <= '0;
    end else begin
      state <= state_next;
      if (push) begin
        out_v <= 1'b1;
        out_q <= push_data;
      end else if (res.ready) begin
        out_v <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (qvalid) begin
            cmdq <= qdata;
            resp <= idle_resp;
            unique case (qdata.op)
              ACT_SCHEDULE: begin
                if (!full) begin
                  valid[free_idx] <= 1'b1;
                  ic              <= ic + ORDER_W'(1);
                end
              end
              ACT_CANCEL: begin
                if (in_range && valid[qidx]) begin
                  valid[qidx] <= 1'b0;
                end
              end
              ACT_TICK: begin
                scan_cnt <= '0;
                found    <= 1'b0;
                rd_vld   <= 1'b0;
              end
              default: begin
              end
            endcase
          end
        end
        ST_QUERY: begin
          resp <= query_resp;
        end
        ST_SCAN: begin
          rd_vld <= scan_issue;
          rd_idx <= scan_cnt[IW-1:0];
          if (scan_issue) begin
            scan_cnt <= scan_cnt + CW'(1);
          end
          if (hit && (!found || age < best_age)) begin
            found    <= 1'b1;
            best     <= rd_idx;
            best_age <= age;
            best_tag <= rd_data.tag;
          end
        end
        ST_DONE: begin
          if (!have_pend || can_push) begin
            if (found) begin
              pend        <= fire_resp;
              have_pend   <= 1'b1;
              valid[best] <= 1'b0;
              scan_cnt    <= '0;
              found       <= 1'b0;
            end else begin
              now       <= now + TIME_BITS'(1);
              have_pend <= 1'b0;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign res.valid = out_v;
  assign res.data  = out_q;

endmodule

>>> rtl/core/timing_wheel_event_scheduler_unit.sv
// Timer event scheduler: schedule, cancel, query and tick over a fixed entry store.
// Schedule and cancel acks pass through the RESP state into the result register;
// queries first pass the QUERY state to read the entry. A tick scans the whole
// store each pass through the single read port of the entry memory and runs one
// pass per fired event plus one. Requests queue two deep while the back end works.
// Synchronous reset clears all valid bits, time and insert count; no clearing pass.
module timing_wheel_event_scheduler_unit #(
  parameter int CAPACITY  = tws_pkg::CAPACITY_DEF,
  parameter int TIME_BITS = tws_pkg::TIME_BITS_DEF
) (
  input logic      clk,
  input logic      rst,
  tws_chan_if.sink   cmd,
  tws_chan_if.source res
);
  import tws_pkg::*;

  qitem_t qdata;
  logic   qvalid;
  logic   qpop;

  tws_front u_front (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .qdata  (qdata),
    .qvalid (qvalid),
    .qpop   (qpop)
  );

  tws_back #(
    .CAPACITY  (CAPACITY),
    .TIME_BITS (TIME_BITS)
  ) u_back (
    .clk    (clk),
    .rst    (rst),
    .qdata  (qdata),
    .qvalid (qvalid),
    .qpop   (qpop),
    .res    (res)
  );

  a_pop_valid: assert property (@(posedge clk) disable iff (rst) qpop |-> qvalid)
    else $error("queue popped while empty");

  a_reset_idle: assert property (@(posedge clk) rst |=> !res.valid)
    else $error("result valid right after reset");

  a_last_fired: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.data.last) |-> (res.data.kind == KIND_FIRED))
    else $error("last flag on a result that is not a fired event");

endmodule
